### rtl/dmc_pkg.sv
// Shared constants, types, microcode table and helpers of the maze carver.
package dmc_pkg;

   // ---------------- geometry ----------------
   localparam int MAX_DIM  = 32;
   localparam int DIM_BITS = $clog2(MAX_DIM);          // one coordinate in the store
   localparam int DIM_W    = $clog2(MAX_DIM + 1);      // a dimension, 1..MAX_DIM
   localparam int CELLS    = MAX_DIM * MAX_DIM;
   localparam int CELL_AW  = 2 * DIM_BITS;             // store address is {y, x}
   localparam int SLOTS    = 1 << CELL_AW;
   localparam int STK_AW   = $clog2(CELLS);
   localparam int LVL_W    = $clog2(CELLS + 1);
   localparam int AREA_W   = 2 * DIM_W;

   // ---------------- field widths ----------------
   localparam int CFG_W     = 6;
   localparam int CMD_W     = 2;
   localparam int RND_W     = 16;
   localparam int COORD_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CELL_W    = 5;   // up, down, left, right, visited

   localparam logic [CFG_W-1:0] DIM_RESET = 6'd21;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // cell word
   localparam logic [CELL_W-1:0] CELL_WALLS   = 5'b01111;
   localparam logic [CELL_W-1:0] CELL_VISITED = 5'b10000;
   localparam int               VIS_BIT      = 4;

   // directions, in gather order
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic       found;
      logic [1:0] dir;
   } pick_type;

   // ---------------- microcode ----------------
   localparam int UPC_W = 4;

   // cell store read address
   localparam logic [2:0] RD_CUR   = 3'd0;
   localparam logic [2:0] RD_UP    = 3'd1;
   localparam logic [2:0] RD_DOWN  = 3'd2;
   localparam logic [2:0] RD_LEFT  = 3'd3;
   localparam logic [2:0] RD_RIGHT = 3'd4;
   localparam logic [2:0] RD_XY    = 3'd5;

   // capture of read data
   localparam logic [2:0] CAP_NONE  = 3'd0;
   localparam logic [2:0] CAP_UP    = 3'd1;
   localparam logic [2:0] CAP_DOWN  = 3'd2;
   localparam logic [2:0] CAP_LEFT  = 3'd3;
   localparam logic [2:0] CAP_RIGHT = 3'd4;
   localparam logic [2:0] CAP_CUR   = 3'd5;

   // cell store write
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_SWEEP = 2'd1;
   localparam logic [1:0] WR_NEXT  = 2'd2;
   localparam logic [1:0] WR_CUR   = 2'd3;

   // datapath operation
   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_INIT     = 4'd1;
   localparam logic [3:0] OP_CHOOSE   = 4'd2;
   localparam logic [3:0] OP_PUSH     = 4'd3;
   localparam logic [3:0] OP_MOVE     = 4'd4;
   localparam logic [3:0] OP_POP      = 4'd5;
   localparam logic [3:0] OP_LOAD     = 4'd6;
   localparam logic [3:0] OP_RESP_CUR = 4'd7;
   localparam logic [3:0] OP_RESP_XY  = 4'd8;

   // jump conditions
   localparam logic [2:0] JC_NEVER      = 3'd0;
   localparam logic [2:0] JC_ALWAYS     = 3'd1;
   localparam logic [2:0] JC_FINISHED   = 3'd2;
   localparam logic [2:0] JC_NO_CHOICE  = 3'd3;
   localparam logic [2:0] JC_STACK_NONE = 3'd4;
   localparam logic [2:0] JC_SWEEP_MORE = 3'd5;

   // program addresses
   localparam logic [UPC_W-1:0] UA_CLEAR    = 4'd0;
   localparam logic [UPC_W-1:0] UA_REPORT   = 4'd1;
   localparam logic [UPC_W-1:0] UA_RESP_CUR = 4'd2;
   localparam logic [UPC_W-1:0] UA_STEP     = 4'd3;
   localparam logic [UPC_W-1:0] UA_RD_DOWN  = 4'd4;
   localparam logic [UPC_W-1:0] UA_RD_LEFT  = 4'd5;
   localparam logic [UPC_W-1:0] UA_RD_RIGHT = 4'd6;
   localparam logic [UPC_W-1:0] UA_RD_CUR   = 4'd7;
   localparam logic [UPC_W-1:0] UA_CHOOSE   = 4'd8;
   localparam logic [UPC_W-1:0] UA_CARVE    = 4'd9;
   localparam logic [UPC_W-1:0] UA_MOVE     = 4'd10;
   localparam logic [UPC_W-1:0] UA_BACK     = 4'd11;
   localparam logic [UPC_W-1:0] UA_POP      = 4'd12;
   localparam logic [UPC_W-1:0] UA_LOAD     = 4'd13;
   localparam logic [UPC_W-1:0] UA_READ     = 4'd14;
   localparam logic [UPC_W-1:0] UA_RESP_XY  = 4'd15;

   typedef struct packed {
      logic [2:0]       rd;
      logic [2:0]       cap;
      logic [1:0]       wr;
      logic [3:0]       op;
      logic [2:0]       jc;
      logic [UPC_W-1:0] target;
      logic             last;
   } ucw_type;

   function automatic ucw_type ucode(input logic [UPC_W-1:0] addr);
      ucw_type w;
      w = '{rd: RD_CUR, cap: CAP_NONE, wr: WR_NONE, op: OP_NONE,
            jc: JC_NEVER, target: UA_CLEAR, last: 1'b0};
      case (addr)
         UA_CLEAR: begin
            w.wr = WR_SWEEP; w.op = OP_INIT;
            w.jc = JC_SWEEP_MORE; w.target = UA_CLEAR;
         end
         UA_REPORT:   w.rd = RD_CUR;
         UA_RESP_CUR: begin
            w.op = OP_RESP_CUR; w.last = 1'b1;
         end
         UA_STEP: begin
            w.rd = RD_UP; w.jc = JC_FINISHED; w.target = UA_REPORT;
         end
         UA_RD_DOWN: begin
            w.rd = RD_DOWN; w.cap = CAP_UP;
         end
         UA_RD_LEFT: begin
            w.rd = RD_LEFT; w.cap = CAP_DOWN;
         end
         UA_RD_RIGHT: begin
            w.rd = RD_RIGHT; w.cap = CAP_LEFT;
         end
         UA_RD_CUR: begin
            w.rd = RD_CUR; w.cap = CAP_RIGHT;
         end
         UA_CHOOSE: begin
            w.cap = CAP_CUR; w.op = OP_CHOOSE;
            w.jc = JC_NO_CHOICE; w.target = UA_BACK;
         end
         UA_CARVE: begin
            w.wr = WR_NEXT; w.op = OP_PUSH;
         end
         UA_MOVE: begin
            w.wr = WR_CUR; w.op = OP_MOVE;
            w.jc = JC_ALWAYS; w.target = UA_REPORT;
         end
         UA_BACK: begin
            w.jc = JC_STACK_NONE; w.target = UA_REPORT;
         end
         UA_POP:  w.op = OP_POP;
         UA_LOAD: begin
            w.op = OP_LOAD; w.jc = JC_ALWAYS; w.target = UA_REPORT;
         end
         UA_READ:    w.rd = RD_XY;
         UA_RESP_XY: begin
            w.op = OP_RESP_XY; w.last = 1'b1;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] entry_point(input logic [CMD_W-1:0] cmd);
      logic [UPC_W-1:0] a;
      case (cmd)
         CMD_CLEAR: a = UA_CLEAR;
         CMD_STEP:  a = UA_STEP;
         CMD_READ:  a = UA_READ;
         default:   a = UA_REPORT;
      endcase
      return a;
   endfunction

   // zero counts as one, anything above the store size as the store size
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (32'(v) > 32'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = DIM_W'(v);
      return r;
   endfunction

endpackage

### rtl/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dmc_pick.sv
// Neighbor selection: candidate mask, random modulo count, chosen direction.
module dmc_pick (
   input  logic [dmc_pkg::DIM_BITS-1:0] cur_x,
   input  logic [dmc_pkg::DIM_BITS-1:0] cur_y,
   input  logic [dmc_pkg::DIM_W-1:0]    dim_w,
   input  logic [dmc_pkg::DIM_W-1:0]    dim_h,
   input  logic [3:0]                   nb_visited,
   input  logic [dmc_pkg::RND_W-1:0]    rnd,
   output dmc_pkg::pick_type            choice
);

   // base-4 digit sum, since 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [dmc_pkg::RND_W-1:0] v);
      logic [5:0] s;
      logic [2:0] f;
      s = '0;
      for (int i = 0; i < dmc_pkg::RND_W / 2; i++) begin
         s = s + 6'(v[2*i +: 2]);
      end
      f = 3'(s[5:4]) + 3'(s[3:2]) + 3'(s[1:0]);
      if (f >= 3'd6) f = f - 3'd6;
      else if (f >= 3'd3) f = f - 3'd3;
      return f[1:0];
   endfunction

   logic [dmc_pkg::DIM_W-1:0] x_e;
   logic [dmc_pkg::DIM_W-1:0] y_e;
   logic                      x_in;
   logic                      y_in;
   logic [3:0]                mask;
   logic [2:0]                count;
   logic [1:0]                k;
   logic [2:0]                seen;
   logic [1:0]                dir;

   always_comb begin
      x_e  = dmc_pkg::DIM_W'(cur_x);
      y_e  = dmc_pkg::DIM_W'(cur_y);
      x_in = x_e < dim_w;
      y_in = y_e < dim_h;

      mask[dmc_pkg::DIR_UP]    = (y_e != '0) && ((y_e - 1'b1) < dim_h) && x_in
                                 && !nb_visited[dmc_pkg::DIR_UP];
      mask[dmc_pkg::DIR_DOWN]  = ((y_e + 1'b1) < dim_h) && x_in
                                 && !nb_visited[dmc_pkg::DIR_DOWN];
      mask[dmc_pkg::DIR_LEFT]  = (x_e != '0) && ((x_e - 1'b1) < dim_w) && y_in
                                 && !nb_visited[dmc_pkg::DIR_LEFT];
      mask[dmc_pkg::DIR_RIGHT] = ((x_e + 1'b1) < dim_w) && y_in
                                 && !nb_visited[dmc_pkg::DIR_RIGHT];

      count = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);

      case (count)
         3'd2:    k = {1'b0, rnd[0]};
         3'd3:    k = mod3(rnd);
         3'd4:    k = rnd[1:0];
         default: k = 2'd0;
      endcase

      // k-th set bit of the mask
      seen = '0;
      dir  = dmc_pkg::DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            if (seen == 3'(k)) dir = 2'(i);
            seen = seen + 3'd1;
         end
      end

      choice.found = count != '0;
      choice.dir   = dir;
   end

endmodule

### rtl/dfs_maze_carver_core.sv
// Top level of the depth-first maze carver: microcoded sequencer and datapath.
//
//  channel   ports                                    handshake
//  --------  ---------------------------------------  ---------------------------------
//  command   req_command/random_value/read_x/read_y   start & !busy at a rising edge
//  result    rsp_cell_x ... rsp_finished              rsp_valid high for one cycle
//  config    csr_index, csr_data                      csr_valid & csr_ready (always ready)
//
// One store read port: neighbors and current cell come one per cycle, and the clear
// sweeps every store entry, one per cycle. busy drops as the strobe rises, so the next
// command can be taken in the strobe cycle. Reset runs the same sweep silently and
// loads 21 into both dimensions; no stalls.
module dfs_maze_carver_core (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            start,
   output logic                            busy,
   input  logic [dmc_pkg::CMD_W-1:0]       req_command,
   input  logic [dmc_pkg::RND_W-1:0]       req_random_value,
   input  logic [dmc_pkg::COORD_W-1:0]     req_read_x,
   input  logic [dmc_pkg::COORD_W-1:0]     req_read_y,

   output logic                            rsp_valid,
   output logic [dmc_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic [dmc_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic                            rsp_wall_up,
   output logic                            rsp_wall_down,
   output logic                            rsp_wall_left,
   output logic                            rsp_wall_right,
   output logic                            rsp_carved,
   output logic                            rsp_backtracked,
   output logic                            rsp_finished,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmc_pkg::CFG_W-1:0]       csr_data
);

   localparam int DB = dmc_pkg::DIM_BITS;
   localparam int CW = dmc_pkg::CELL_W;

   // ---------------- sequencer and control state ----------------
   logic                          busy_ff, busy_in;
   logic [dmc_pkg::UPC_W-1:0]     upc_ff, upc_in;
   logic                          resp_en_ff, resp_en_in;   // reset sweep stays silent
   logic [dmc_pkg::CELL_AW-1:0]   sweep_ff, sweep_in;
   logic [DB-1:0]                 cur_x_ff, cur_x_in;
   logic [DB-1:0]                 cur_y_ff, cur_y_in;
   logic [dmc_pkg::LVL_W-1:0]     level_ff, level_in;
   logic [dmc_pkg::LVL_W-1:0]     visited_ff, visited_in;
   logic                          carved_ff, carved_in;
   logic                          back_ff, back_in;
   logic [dmc_pkg::CFG_W-1:0]     maze_width_ff, maze_width_in;
   logic [dmc_pkg::CFG_W-1:0]     maze_height_ff, maze_height_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // ---------------- payload registers ----------------
   logic [CW-1:0]                 nb_ff [4];
   logic [CW-1:0]                 nb_in [4];
   logic [CW-1:0]                 curv_ff, curv_in;
   logic [1:0]                    dir_ff, dir_in;
   logic [dmc_pkg::RND_W-1:0]     rnd_ff, rnd_in;
   logic [dmc_pkg::COORD_W-1:0]   rx_ff, rx_in;
   logic [dmc_pkg::COORD_W-1:0]   ry_ff, ry_in;
   logic [dmc_pkg::COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [dmc_pkg::COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [3:0]                    rsp_walls_ff, rsp_walls_in;
   logic                          rsp_carved_ff, rsp_carved_in;
   logic                          rsp_back_ff, rsp_back_in;
   logic                          rsp_fin_ff, rsp_fin_in;

   // ---------------- datapath wires ----------------
   dmc_pkg::ucw_type              word;
   dmc_pkg::pick_type             choice;
   logic                          accept;
   logic                          take;
   logic [dmc_pkg::DIM_W-1:0]     dim_w;
   logic [dmc_pkg::DIM_W-1:0]     dim_h;
   logic [dmc_pkg::AREA_W-1:0]    area;
   logic                          finished;
   logic [DB-1:0]                 nb_x [4];
   logic [DB-1:0]                 nb_y [4];
   logic [3:0]                    nb_visited;
   logic [DB-1:0]                 rx_s, ry_s;
   logic                          rxy_out;

   logic                          cell_we;
   logic [dmc_pkg::CELL_AW-1:0]   cell_waddr, cell_raddr;
   logic [CW-1:0]                 cell_wdata, cell_rdata;
   logic                          stk_we;
   logic [dmc_pkg::LVL_W-1:0]     level_dec;
   logic [dmc_pkg::CELL_AW-1:0]   stk_rdata;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign word      = dmc_pkg::ucode(upc_ff);

   // live, clamped bounds; the done test compares against their product
   assign dim_w    = dmc_pkg::clamp_dim(maze_width_ff);
   assign dim_h    = dmc_pkg::clamp_dim(maze_height_ff);
   assign area     = dmc_pkg::AREA_W'(dim_w) * dmc_pkg::AREA_W'(dim_h);
   assign finished = (dmc_pkg::AREA_W + dmc_pkg::LVL_W)'(visited_ff)
                     >= (dmc_pkg::AREA_W + dmc_pkg::LVL_W)'(area);

   // neighbor coordinates; wrapped values are masked out by the bounds tests
   always_comb begin
      nb_x[dmc_pkg::DIR_UP]    = cur_x_ff;
      nb_y[dmc_pkg::DIR_UP]    = cur_y_ff - 1'b1;
      nb_x[dmc_pkg::DIR_DOWN]  = cur_x_ff;
      nb_y[dmc_pkg::DIR_DOWN]  = cur_y_ff + 1'b1;
      nb_x[dmc_pkg::DIR_LEFT]  = cur_x_ff - 1'b1;
      nb_y[dmc_pkg::DIR_LEFT]  = cur_y_ff;
      nb_x[dmc_pkg::DIR_RIGHT] = cur_x_ff + 1'b1;
      nb_y[dmc_pkg::DIR_RIGHT] = cur_y_ff;
      for (int i = 0; i < 4; i++) begin
         nb_visited[i] = nb_ff[i][dmc_pkg::VIS_BIT];
      end
   end

   dmc_pick u_pick (
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .dim_w      (dim_w),
      .dim_h      (dim_h),
      .nb_visited (nb_visited),
      .rnd        (rnd_ff),
      .choice     (choice)
   );

   // read coordinates beyond the store report all four walls
   assign rx_s    = DB'(rx_ff);
   assign ry_s    = DB'(ry_ff);
   assign rxy_out = (32'(rx_ff) >= 32'(dmc_pkg::MAX_DIM))
                 || (32'(ry_ff) >= 32'(dmc_pkg::MAX_DIM));

   // ---------------- cell store ports ----------------
   always_comb begin
      case (word.rd)
         dmc_pkg::RD_UP:    cell_raddr = {nb_y[dmc_pkg::DIR_UP],    nb_x[dmc_pkg::DIR_UP]};
         dmc_pkg::RD_DOWN:  cell_raddr = {nb_y[dmc_pkg::DIR_DOWN],  nb_x[dmc_pkg::DIR_DOWN]};
         dmc_pkg::RD_LEFT:  cell_raddr = {nb_y[dmc_pkg::DIR_LEFT],  nb_x[dmc_pkg::DIR_LEFT]};
         dmc_pkg::RD_RIGHT: cell_raddr = {nb_y[dmc_pkg::DIR_RIGHT], nb_x[dmc_pkg::DIR_RIGHT]};
         dmc_pkg::RD_XY:    cell_raddr = {ry_s, rx_s};
         default:           cell_raddr = {cur_y_ff, cur_x_ff};
      endcase

      cell_we = busy_ff && (word.wr != dmc_pkg::WR_NONE);
      case (word.wr)
         dmc_pkg::WR_SWEEP: begin
            cell_waddr = sweep_ff;
            cell_wdata = (sweep_ff == '0) ? (dmc_pkg::CELL_WALLS | dmc_pkg::CELL_VISITED)
                                          : dmc_pkg::CELL_WALLS;
         end
         dmc_pkg::WR_NEXT: begin
            // entered cell loses the wall facing back toward us
            cell_waddr = {nb_y[dir_ff], nb_x[dir_ff]};
            cell_wdata = (nb_ff[dir_ff] & ~(CW'(1) << (dir_ff ^ 2'b01)))
                         | dmc_pkg::CELL_VISITED;
         end
         dmc_pkg::WR_CUR: begin
            cell_waddr = {cur_y_ff, cur_x_ff};
            cell_wdata = curv_ff & ~(CW'(1) << dir_ff);
         end
         default: begin
            cell_waddr = sweep_ff;
            cell_wdata = dmc_pkg::CELL_WALLS;
         end
      endcase
   end

   dmc_ram #(
      .WIDTH (CW),
      .DEPTH (dmc_pkg::SLOTS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   // ---------------- backtrack stack ----------------
   // a push onto a full stack is dropped
   assign stk_we    = busy_ff && (word.op == dmc_pkg::OP_PUSH)
                      && (level_ff < dmc_pkg::LVL_W'(dmc_pkg::CELLS));
   assign level_dec = level_ff - 1'b1;

   dmc_ram #(
      .WIDTH (dmc_pkg::CELL_AW),
      .DEPTH (dmc_pkg::CELLS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (level_ff[dmc_pkg::STK_AW-1:0]),
      .wr_data ({cur_y_ff, cur_x_ff}),
      .rd_addr (level_dec[dmc_pkg::STK_AW-1:0]),
      .rd_data (stk_rdata)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      case (word.jc)
         dmc_pkg::JC_ALWAYS:     take = 1'b1;
         dmc_pkg::JC_FINISHED:   take = finished;
         dmc_pkg::JC_NO_CHOICE:  take = ~choice.found;
         dmc_pkg::JC_STACK_NONE: take = level_ff == '0;
         dmc_pkg::JC_SWEEP_MORE: take = sweep_ff != '1;
         default:                take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in        = busy_ff;
      upc_in         = upc_ff;
      resp_en_in     = resp_en_ff;
      sweep_in       = sweep_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      level_in       = level_ff;
      visited_in     = visited_ff;
      carved_in      = carved_ff;
      back_in        = back_ff;
      maze_width_in  = maze_width_ff;
      maze_height_in = maze_height_ff;
      rsp_valid_in   = 1'b0;

      nb_in          = nb_ff;
      curv_in        = curv_ff;
      dir_in         = dir_ff;
      rnd_in         = rnd_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_walls_in   = rsp_walls_ff;
      rsp_carved_in  = rsp_carved_ff;
      rsp_back_in    = rsp_back_ff;
      rsp_fin_in     = rsp_fin_ff;

      if (csr_valid) begin
         case (csr_index)
            dmc_pkg::CSR_WIDTH:  maze_width_in  = csr_data;
            dmc_pkg::CSR_HEIGHT: maze_height_in = csr_data;
            default: ;
         endcase
      end

      if (accept) begin
         busy_in    = 1'b1;
         upc_in     = dmc_pkg::entry_point(req_command);
         resp_en_in = 1'b1;
         carved_in  = 1'b0;
         back_in    = 1'b0;
         rnd_in     = req_random_value;
         rx_in      = req_read_x;
         ry_in      = req_read_y;
      end else if (busy_ff) begin
         upc_in = take ? word.target : upc_ff + 1'b1;
         if (word.last) busy_in = 1'b0;

         case (word.cap)
            dmc_pkg::CAP_UP:    nb_in[dmc_pkg::DIR_UP]    = cell_rdata;
            dmc_pkg::CAP_DOWN:  nb_in[dmc_pkg::DIR_DOWN]  = cell_rdata;
            dmc_pkg::CAP_LEFT:  nb_in[dmc_pkg::DIR_LEFT]  = cell_rdata;
            dmc_pkg::CAP_RIGHT: nb_in[dmc_pkg::DIR_RIGHT] = cell_rdata;
            dmc_pkg::CAP_CUR:   curv_in                   = cell_rdata;
            default: ;
         endcase

         case (word.op)
            dmc_pkg::OP_INIT: begin
               sweep_in   = sweep_ff + 1'b1;
               cur_x_in   = '0;
               cur_y_in   = '0;
               level_in   = '0;
               visited_in = dmc_pkg::LVL_W'(1);
            end
            dmc_pkg::OP_CHOOSE: dir_in = choice.dir;
            dmc_pkg::OP_PUSH: begin
               if (level_ff < dmc_pkg::LVL_W'(dmc_pkg::CELLS)) level_in = level_ff + 1'b1;
            end
            dmc_pkg::OP_MOVE: begin
               cur_x_in  = nb_x[dir_ff];
               cur_y_in  = nb_y[dir_ff];
               carved_in = 1'b1;
               if (visited_ff != '1) visited_in = visited_ff + 1'b1;
            end
            dmc_pkg::OP_POP: begin
               level_in = level_dec;
               back_in  = 1'b1;
            end
            dmc_pkg::OP_LOAD: begin
               cur_x_in = stk_rdata[DB-1:0];
               cur_y_in = stk_rdata[dmc_pkg::CELL_AW-1:DB];
            end
            dmc_pkg::OP_RESP_CUR: begin
               rsp_valid_in  = resp_en_ff;
               rsp_x_in      = dmc_pkg::COORD_W'(cur_x_ff);
               rsp_y_in      = dmc_pkg::COORD_W'(cur_y_ff);
               rsp_walls_in  = cell_rdata[3:0];
               rsp_carved_in = carved_ff;
               rsp_back_in   = back_ff;
               rsp_fin_in    = finished;
            end
            dmc_pkg::OP_RESP_XY: begin
               rsp_valid_in  = resp_en_ff;
               rsp_x_in      = rx_ff;
               rsp_y_in      = ry_ff;
               rsp_walls_in  = rxy_out ? dmc_pkg::CELL_WALLS[3:0] : cell_rdata[3:0];
               rsp_carved_in = 1'b0;
               rsp_back_in   = 1'b0;
               rsp_fin_in    = finished;
            end
            default: ;
         endcase
      end
   end

   // control state; reset starts the clearing sweep with no result
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         upc_ff         <= dmc_pkg::UA_CLEAR;
         resp_en_ff     <= 1'b0;
         sweep_ff       <= '0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         level_ff       <= '0;
         visited_ff     <= dmc_pkg::LVL_W'(1);
         carved_ff      <= 1'b0;
         back_ff        <= 1'b0;
         maze_width_ff  <= dmc_pkg::DIM_RESET;
         maze_height_ff <= dmc_pkg::DIM_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         upc_ff         <= upc_in;
         resp_en_ff     <= resp_en_in;
         sweep_ff       <= sweep_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         level_ff       <= level_in;
         visited_ff     <= visited_in;
         carved_ff      <= carved_in;
         back_ff        <= back_in;
         maze_width_ff  <= maze_width_in;
         maze_height_ff <= maze_height_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      nb_ff         <= nb_in;
      curv_ff       <= curv_in;
      dir_ff        <= dir_in;
      rnd_ff        <= rnd_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_walls_ff  <= rsp_walls_in;
      rsp_carved_ff <= rsp_carved_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_x      = rsp_x_ff;
   assign rsp_cell_y      = rsp_y_ff;
   assign rsp_wall_up     = rsp_walls_ff[dmc_pkg::DIR_UP];
   assign rsp_wall_down   = rsp_walls_ff[dmc_pkg::DIR_DOWN];
   assign rsp_wall_left   = rsp_walls_ff[dmc_pkg::DIR_LEFT];
   assign rsp_wall_right  = rsp_walls_ff[dmc_pkg::DIR_RIGHT];
   assign rsp_carved      = rsp_carved_ff;
   assign rsp_backtracked = rsp_back_ff;
   assign rsp_finished    = rsp_fin_ff;

endmodule
